// ===== hdl/voxent_pkg.sv =====
// Shared constants, types and elaboration-time tables for the voxel entropy block.
package voxent_pkg;

    // Lane and field geometry.
    localparam int LANES = 8;
    localparam int VALUE_W = 16;
    localparam int SCALE_W = 17;
    localparam int LCNT_W = 4;
    localparam int ENT_W = 16;
    localparam int MIN_LABELS = 2;

    // Probability format: Q.16, saturating at 1.0.
    localparam int P_FRAC = 16;
    localparam int P_W = P_FRAC + 1;
    localparam logic [P_W-1:0] P_ONE = P_W'(1) << P_FRAC;

    // Logarithm format: integer part in EXP_W bits, FRAC_BITS fraction bits.
    localparam int FRAC_BITS = 24;
    localparam int EXP_W = 5;
    localparam int LOG_W = EXP_W + FRAC_BITS;
    localparam logic [LOG_W-1:0] LOG_ONE = LOG_W'(P_FRAC) << FRAC_BITS;

    // Mantissa in Q1.30 while squaring.
    localparam int MANT_FRAC = 30;
    localparam int MANT_W = MANT_FRAC + 1;

    // Per-lane term p * (-log2 p) in Q.40 and the sum over the lanes.
    localparam int TERM_W = P_FRAC + FRAC_BITS;
    localparam int TREE_LAT = $clog2(LANES);
    localparam int TREE_N = 1 << TREE_LAT;
    localparam int SUM_W = TERM_W + TREE_LAT;
    localparam int HB_W = SUM_W - P_FRAC;

    // Natural log of two in Q.30.
    localparam int LN2_FRAC = 30;
    localparam logic [LN2_FRAC-1:0] LN2_Q30 = LN2_FRAC'(744261118);

    // Divider geometry for the normalized result.
    localparam int LOG2N_W = $clog2(LANES) + FRAC_BITS;
    localparam int QUO_W = HB_W;
    localparam int DVD_W = HB_W + FRAC_BITS;

    // Output clamp and rounding to Q2.14.
    localparam int CLAMP_W = (HB_W > LOG2N_W) ? HB_W : LOG2N_W;
    localparam int ROUND_SHIFT = 10;
    localparam logic [CLAMP_W:0] ROUND_HALF = (CLAMP_W + 1)'(1) << (ROUND_SHIFT - 1);

    // Pipeline depth from item acceptance to the last divider stage.
    localparam int LANE_LAT = FRAC_BITS + 3;
    localparam int PIPE_DEPTH = LANE_LAT + TREE_LAT + 1 + QUO_W;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LABEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROB_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZE = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [LCNT_W-1:0] LABEL_COUNT_RST = LCNT_W'(8);
    localparam logic [SCALE_W-1:0] PROB_SCALE_RST = SCALE_W'(65536);

    typedef logic [LANES:0][LOG2N_W-1:0] lcount_tab_t;

    // Bit-exact log2 by repeated squaring; evaluated only on constants.
    function automatic logic [LOG_W-1:0] log2_q24(input int unsigned x);
        int unsigned e;
        logic [63:0] m;
        logic [FRAC_BITS-1:0] frac;
        e = 0;
        for (int i = 0; i < P_FRAC; i++)
        begin
            if ((x >> (e + 1)) != 0)
            begin
                e = e + 1;
            end
        end
        m = 64'(x) << (MANT_FRAC - e);
        frac = '0;
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            m = (m * m) >> MANT_FRAC;
            frac = {frac[FRAC_BITS-2:0], 1'b0};
            if (m >= (64'd1 << (MANT_FRAC + 1)))
            begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return {EXP_W'(e), frac};
    endfunction

    // log2 of the label count, indexed by the effective label count.
    function automatic lcount_tab_t build_log2n_tab();
        lcount_tab_t tab;
        for (int n = 0; n <= LANES; n++)
        begin
            tab[n] = LOG2N_W'(log2_q24((n < MIN_LABELS) ? MIN_LABELS : n));
        end
        return tab;
    endfunction

    // Upper clamp ln(N) in Q.24, indexed by the effective label count.
    function automatic lcount_tab_t build_lim_tab();
        lcount_tab_t tab;
        lcount_tab_t l2;
        l2 = build_log2n_tab();
        for (int n = 0; n <= LANES; n++)
        begin
            tab[n] = LOG2N_W'((64'(l2[n]) * 64'(LN2_Q30)) >> LN2_FRAC);
        end
        return tab;
    endfunction

    localparam lcount_tab_t LOG2N_TAB = build_log2n_tab();
    localparam lcount_tab_t LIM_TAB = build_lim_tab();

endpackage

// ===== hdl/voxent_lane.sv =====
// One lane: scales a value to a probability and forms p * (-log2 p) over a squaring pipeline.
module voxent_lane (
    input  logic                              clk,
    input  logic                              en,
    input  logic [voxent_pkg::VALUE_W-1:0]    value,
    input  logic [voxent_pkg::SCALE_W-1:0]    prob_scale,
    input  logic                              active,
    output logic [voxent_pkg::TERM_W-1:0]     term
);
    import voxent_pkg::*;

    localparam int PROD_W = VALUE_W + SCALE_W;
    localparam int SQ_W = 2 * MANT_W;
    localparam int TPROD_W = P_W + LOG_W;
    localparam logic [PROD_W-1:0] P_ONE_WIDE = PROD_W'(P_ONE);

    logic [PROD_W-1:0]    scaled;
    logic [P_W-1:0]       p_a_next;
    logic [P_W-1:0]       p_a_reg;
    logic [EXP_W-1:0]     e_b_next;
    logic [MANT_W-1:0]    m_b_next;
    logic [P_W-1:0]       p_reg [FRAC_BITS+1];
    logic [EXP_W-1:0]     e_reg [FRAC_BITS+1];
    logic [MANT_W-1:0]    m_reg [FRAC_BITS];
    logic [FRAC_BITS-1:0] frac_reg [FRAC_BITS];
    logic [LOG_W-1:0]     log2_val;
    logic [LOG_W-1:0]     neg_log2;
    logic [TPROD_W-1:0]   term_next;
    logic [TERM_W-1:0]    term_reg;

    // Scale to a probability and saturate at 1.0; unused lanes give zero.
    always_comb
    begin
        scaled = PROD_W'(value) * PROD_W'(prob_scale);
        if (!active)
        begin
            p_a_next = '0;
        end
        else if (scaled > P_ONE_WIDE)
        begin
            p_a_next = P_ONE;
        end
        else
        begin
            p_a_next = scaled[P_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_a_reg <= p_a_next;
        end
    end

    // Find the leading one and align the probability to a Q1.30 mantissa.
    always_comb
    begin
        e_b_next = '0;
        for (int b = 1; b < P_W; b++)
        begin
            if (p_a_reg[b])
            begin
                e_b_next = EXP_W'(b);
            end
        end
        m_b_next = MANT_W'(p_a_reg) << (EXP_W'(MANT_FRAC) - e_b_next);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= p_a_reg;
            e_reg[0] <= e_b_next;
            m_reg[0] <= m_b_next;
        end
    end

    // Each stage squares the mantissa once and yields one fraction bit.
    genvar k;
    for (k = 0; k < FRAC_BITS; k++)
    begin : g_sq
        logic [SQ_W-1:0]      sq;
        logic [MANT_W:0]      sq_top;
        logic [FRAC_BITS-1:0] frac_in;

        assign sq = SQ_W'(m_reg[k]) * SQ_W'(m_reg[k]);
        assign sq_top = sq[SQ_W-1:MANT_FRAC];

        if (k == 0)
        begin : g_first
            assign frac_in = '0;
        end
        else
        begin : g_next
            assign frac_in = frac_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[k+1] <= p_reg[k];
                e_reg[k+1] <= e_reg[k];
                frac_reg[k] <= {frac_in[FRAC_BITS-2:0], sq_top[MANT_W]};
            end
        end

        // The mantissa after the last square is not needed.
        if (k < FRAC_BITS - 1)
        begin : g_mant
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    m_reg[k+1] <= sq_top[MANT_W] ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
                end
            end
        end
    end

    // Term p * (16 - log2 p); a zero probability gives zero through the product.
    always_comb
    begin
        log2_val = {e_reg[FRAC_BITS], frac_reg[FRAC_BITS-1]};
        neg_log2 = LOG_ONE - log2_val;
        term_next = TPROD_W'(p_reg[FRAC_BITS]) * TPROD_W'(neg_log2);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            term_reg <= term_next[TERM_W-1:0];
        end
    end

    assign term = term_reg;

endmodule

// ===== hdl/voxent_merge.sv =====
// Registered adder tree that sums the lane terms.
module voxent_merge (
    input  logic                           clk,
    input  logic                           en,
    input  logic [voxent_pkg::TERM_W-1:0]  term [voxent_pkg::LANES],
    output logic [voxent_pkg::SUM_W-1:0]   sum
);
    import voxent_pkg::*;

    logic [SUM_W-1:0] leaf [TREE_N];
    logic [SUM_W-1:0] node_reg [1:TREE_N-1];

    // Leaves: lane terms, padded with zeros up to a power of two.
    genvar j;
    for (j = 0; j < TREE_N; j++)
    begin : g_leaf
        if (j < LANES)
        begin : g_used
            assign leaf[j] = SUM_W'(term[j]);
        end
        else
        begin : g_pad
            assign leaf[j] = '0;
        end
    end

    // Heap-ordered nodes: node k adds children 2k and 2k+1, with a register at every level.
    genvar n;
    for (n = 1; n < TREE_N; n++)
    begin : g_node
        if (2 * n >= TREE_N)
        begin : g_bottom
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    node_reg[n] <= leaf[2*n-TREE_N] + leaf[2*n+1-TREE_N];
                end
            end
        end
        else
        begin : g_inner
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    node_reg[n] <= node_reg[2*n] + node_reg[2*n+1];
                end
            end
        end
    end

    assign sum = node_reg[1];

endmodule

// ===== hdl/voxent_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side value carried along.
module voxent_div (
    input  logic                            clk,
    input  logic                            en,
    input  logic [voxent_pkg::LOG2N_W-1:0]  divisor,
    input  logic [voxent_pkg::DVD_W-1:0]    dividend,
    input  logic [voxent_pkg::HB_W-1:0]     side_in,
    output logic [voxent_pkg::QUO_W-1:0]    quotient,
    output logic [voxent_pkg::HB_W-1:0]     side_out
);
    import voxent_pkg::*;

    logic [LOG2N_W-1:0] r_reg [QUO_W-1];
    logic [DVD_W-1:0]   dvd_reg [QUO_W-1];
    logic [QUO_W-1:0]   q_reg [QUO_W];
    logic [HB_W-1:0]    side_reg [QUO_W];

    // Stage k decides quotient bit QUO_W-1-k; the remainder stays below the divisor.
    genvar k;
    for (k = 0; k < QUO_W; k++)
    begin : g_stage
        logic [LOG2N_W-1:0] r_cur;
        logic [DVD_W-1:0]   dvd_cur;
        logic [QUO_W-1:0]   q_cur;
        logic [HB_W-1:0]    side_cur;
        logic [LOG2N_W:0]   trial;
        logic [LOG2N_W:0]   diff;
        logic               take;

        if (k == 0)
        begin : g_first
            assign r_cur = LOG2N_W'(dividend[DVD_W-1:QUO_W]);
            assign dvd_cur = dividend;
            assign q_cur = '0;
            assign side_cur = side_in;
        end
        else
        begin : g_next
            assign r_cur = r_reg[k-1];
            assign dvd_cur = dvd_reg[k-1];
            assign q_cur = q_reg[k-1];
            assign side_cur = side_reg[k-1];
        end

        assign trial = {r_cur, dvd_cur[QUO_W-1-k]};
        assign diff = trial - {1'b0, divisor};
        assign take = (trial >= {1'b0, divisor});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k] <= {q_cur[QUO_W-2:0], take};
                side_reg[k] <= side_cur;
            end
        end

        // The last stage has no use for the remainder or the dividend.
        if (k < QUO_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[k] <= take ? diff[LOG2N_W-1:0] : trial[LOG2N_W-1:0];
                    dvd_reg[k] <= dvd_cur;
                end
            end
        end
    end

    assign quotient = q_reg[QUO_W-1];
    assign side_out = side_reg[QUO_W-1];

endmodule

// ===== hdl/voxel_distribution_entropy.sv =====
// An accepted voxel item passes the lanes, the adder tree, the bits and nats register, the divider
// and the output register; results stay in order. A two-entry output stage absorbs stalls.
// Throughput: one voxel item per cycle while the output skid slot is empty, set by the eight
// lanes with 24 squaring stages each and by the 27-stage divider, all fully pipelined.
// Reset: label_count 8, prob_scale 1.0, normalize on; pipeline and output empty.
module voxel_distribution_entropy (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [voxent_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [voxent_pkg::SCALE_W-1:0]    cfg_data,
    // Voxel input channel.
    input  logic                              voxel_valid,
    output logic                              voxel_ready,
    input  logic [voxent_pkg::VALUE_W-1:0]    value_0,
    input  logic [voxent_pkg::VALUE_W-1:0]    value_1,
    input  logic [voxent_pkg::VALUE_W-1:0]    value_2,
    input  logic [voxent_pkg::VALUE_W-1:0]    value_3,
    input  logic [voxent_pkg::VALUE_W-1:0]    value_4,
    input  logic [voxent_pkg::VALUE_W-1:0]    value_5,
    input  logic [voxent_pkg::VALUE_W-1:0]    value_6,
    input  logic [voxent_pkg::VALUE_W-1:0]    value_7,
    // Result channel.
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [voxent_pkg::ENT_W-1:0]      entropy,
    output logic                              was_clamped
);
    import voxent_pkg::*;

    localparam int NAT_PROD_W = HB_W + LN2_FRAC;

    logic [LCNT_W-1:0]     label_count_reg;
    logic [SCALE_W-1:0]    prob_scale_reg;
    logic                  normalize_reg;
    logic [LCNT_W-1:0]     n_eff;
    logic [LOG2N_W-1:0]    log2n;
    logic [LOG2N_W-1:0]    lim;

    logic                  en;
    logic                  voxel_accept;
    logic [PIPE_DEPTH-1:0] valid_reg;

    logic [VALUE_W-1:0]    lane_value [LANES];
    logic [TERM_W-1:0]     lane_term [LANES];
    logic [LANES-1:0]      lane_active;
    logic [SUM_W-1:0]      term_sum;

    logic [HB_W-1:0]       hb;
    logic [NAT_PROD_W-1:0] nat_prod;
    logic [HB_W-1:0]       hb_reg;
    logic [HB_W-1:0]       nat_reg;
    logic [QUO_W-1:0]      quo;
    logic [HB_W-1:0]       nat_out;

    logic [CLAMP_W-1:0]    raw_sel;
    logic [CLAMP_W-1:0]    lim_wide;
    logic [CLAMP_W-1:0]    clamp_val;
    logic [CLAMP_W:0]      rounded;
    logic [ENT_W-1:0]      res_entropy;
    logic                  res_clamped;
    logic                  res_valid;

    logic                  out_valid_reg;
    logic [ENT_W-1:0]      entropy_reg;
    logic                  clamped_reg;
    logic                  skid_valid_reg;
    logic [ENT_W-1:0]      skid_entropy_reg;
    logic                  skid_clamped_reg;

    // Configuration registers; a write to an unknown index is dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_count_reg <= LABEL_COUNT_RST;
            prob_scale_reg <= PROB_SCALE_RST;
            normalize_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LABEL_COUNT: label_count_reg <= cfg_data[LCNT_W-1:0];
                CFG_PROB_SCALE:  prob_scale_reg <= cfg_data;
                CFG_NORMALIZE:   normalize_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Effective label count, held between two and the lane count.
    always_comb
    begin
        if (label_count_reg < LCNT_W'(MIN_LABELS))
        begin
            n_eff = LCNT_W'(MIN_LABELS);
        end
        else if (label_count_reg > LCNT_W'(LANES))
        begin
            n_eff = LCNT_W'(LANES);
        end
        else
        begin
            n_eff = label_count_reg;
        end
        log2n = LOG2N_TAB[n_eff];
        lim = LIM_TAB[n_eff];
    end

    // The whole pipeline advances unless the output skid slot is occupied.
    assign en = !skid_valid_reg;
    assign voxel_ready = en;
    assign voxel_accept = voxel_valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], voxel_accept};
        end
    end

    // Lanes.
    assign lane_value[0] = value_0;
    assign lane_value[1] = value_1;
    assign lane_value[2] = value_2;
    assign lane_value[3] = value_3;
    assign lane_value[4] = value_4;
    assign lane_value[5] = value_5;
    assign lane_value[6] = value_6;
    assign lane_value[7] = value_7;

    genvar i;
    for (i = 0; i < LANES; i++)
    begin : g_lane
        assign lane_active[i] = (LCNT_W'(i) < n_eff);

        voxent_lane u_lane (
            .clk        (clk),
            .en         (en),
            .value      (lane_value[i]),
            .prob_scale (prob_scale_reg),
            .active     (lane_active[i]),
            .term       (lane_term[i])
        );
    end

    // Sum of the lane terms.
    voxent_merge u_merge (
        .clk  (clk),
        .en   (en),
        .term (lane_term),
        .sum  (term_sum)
    );

    // Entropy in bits, and its value in nats for the raw mode.
    always_comb
    begin
        hb = term_sum[SUM_W-1:P_FRAC];
        nat_prod = NAT_PROD_W'(hb) * NAT_PROD_W'(LN2_Q30);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hb_reg <= hb;
            nat_reg <= nat_prod[NAT_PROD_W-1:LN2_FRAC];
        end
    end

    // Normalization: bits divided by log2 of the label count.
    voxent_div u_div (
        .clk      (clk),
        .en       (en),
        .divisor  (log2n),
        .dividend ({hb_reg, {FRAC_BITS{1'b0}}}),
        .side_in  (nat_reg),
        .quotient (quo),
        .side_out (nat_out)
    );

    // Select, clamp at ln(N) and round to Q2.14.
    always_comb
    begin
        raw_sel = normalize_reg ? CLAMP_W'(quo) : CLAMP_W'(nat_out);
        lim_wide = CLAMP_W'(lim);
        res_clamped = (raw_sel > lim_wide);
        clamp_val = res_clamped ? lim_wide : raw_sel;
        rounded = (CLAMP_W + 1)'(clamp_val) + ROUND_HALF;
        res_entropy = rounded[ROUND_SHIFT +: ENT_W];
        res_valid = valid_reg[PIPE_DEPTH-1] && en;
    end

    // Output register with a skid slot behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (result_ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !result_ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (result_ready)
            begin
                entropy_reg <= skid_entropy_reg;
                clamped_reg <= skid_clamped_reg;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || result_ready)
            begin
                entropy_reg <= res_entropy;
                clamped_reg <= res_clamped;
            end
            else
            begin
                skid_entropy_reg <= res_entropy;
                skid_clamped_reg <= res_clamped;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign entropy = entropy_reg;
    assign was_clamped = clamped_reg;

`ifndef ASSERT_OFF
    // The skid slot only fills behind a waiting output item.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot holds an item while the output register is empty");

    // A full skid slot freezes the pipeline.
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> $stable(valid_reg))
        else $error("pipeline moved while the skid slot was full");

    // A finished item meeting a blocked output lands in the skid slot.
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[PIPE_DEPTH-1] && !skid_valid_reg && out_valid_reg && !result_ready)
        |=> skid_valid_reg)
        else $error("finished item was not captured by the skid slot");
`endif

endmodule
